FILE: sv/bthalloc_pkg.sv
// Shared types and constants of the block table heap allocator.
`default_nettype none

package bthalloc_pkg;

   localparam int ADDR_W = 32;
   localparam int TB_W   = 11;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE    = 1'b0;
   localparam logic CSR_TABLE_BLOCKS = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // entry bits
   localparam int ENT_TAKEN = 0;
   localparam int ENT_NEXT  = 1;

   localparam logic [TB_W-1:0] TABLE_BLOCKS_RESET = 11'd1024;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_CHECK,
      S_WALK
   } state_type;

endpackage

`default_nettype wire

FILE: sv/bthalloc_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module bthalloc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/block_table_heap_allocator_top.sv
// First-fit block table heap allocator: sequencer, shared datapath and table RAM.
// A zero-size allocate or an allocate on an empty table answers in the cycle after start without
// going busy; otherwise allocate scans entries for a free run, then marks the run, and free
// does a range check, then walks the chain and clears its entries.
// One item at a time; otherwise busy is high until the rsp_valid strobe. Reset clears the table
// in a pass over all MAX_BLOCKS entries with busy high; csr writes are taken throughout.
`default_nettype none

module block_table_heap_allocator_top
   import bthalloc_pkg::*;
#(
   parameter int BLOCK_BYTES = 4096,
   parameter int MAX_BLOCKS  = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_operation,
   input  wire logic [31:0]       req_size_bytes,
   input  wire logic [31:0]       req_address,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_result_address,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [31:0]       csr_wdata
);

   localparam int AW     = $clog2(MAX_BLOCKS);
   localparam int NW     = $clog2(MAX_BLOCKS + 1);
   localparam int CW     = (NW > TB_W) ? NW : TB_W;
   localparam int RUNW   = $clog2(MAX_BLOCKS) + $clog2(BLOCK_BYTES) + 1;
   localparam int CMPW   = (RUNW > ADDR_W) ? RUNW : ADDR_W;
   localparam int LOG_BB = $clog2(BLOCK_BYTES);

   state_type          state_ff, state_in;
   logic [NW-1:0]      idx_ff, idx_in;
   logic [NW-1:0]      end_ff, end_in;
   logic [NW-1:0]      start_ff, start_in;
   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        start_pos_ff, start_pos_in;
   logic [RUNW-1:0]    run_ff, run_in;
   logic [31:0]        size_ff, size_in;
   logic [31:0]        off_ff, off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [31:0]        heap_base_ff;
   logic [TB_W-1:0]    table_blocks_ff;

   logic [NW-1:0]      n_used;
   logic [CW-1:0]      tb_ext;
   logic [NW-1:0]      idx_nx;
   logic [RUNW-1:0]    new_run;
   logic [NW-1:0]      run_start;
   logic [31:0]        blk;
   logic               accept;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [1:0]         wr_data;
   logic [AW-1:0]      rd_addr;
   logic [1:0]         rd_data;

   bthalloc_ram #(
      .WIDTH (2),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign tb_ext = CW'(table_blocks_ff);
   assign n_used = (tb_ext > CW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : tb_ext[NW-1:0];
   assign idx_nx = idx_ff + 1'b1;
   assign accept = start && !busy;
   assign new_run = run_ff + RUNW'(BLOCK_BYTES);
   assign run_start = (run_ff == '0) ? idx_ff : start_ff;
   // block index of the free offset
   assign blk = off_ff >> LOG_BB;

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff    <= '0;
         table_blocks_ff <= TABLE_BLOCKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEAP_BASE:    heap_base_ff    <= csr_wdata;
            CSR_TABLE_BLOCKS: table_blocks_ff <= csr_wdata[TB_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff        <= end_in;
      start_ff      <= start_in;
      pos_ff        <= pos_in;
      start_pos_ff  <= start_pos_in;
      run_ff        <= run_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      start_in      = start_ff;
      pos_in        = pos_ff;
      start_pos_in  = start_pos_ff;
      run_in        = run_ff;
      size_in       = size_ff;
      off_in        = off_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = 2'b00;
      rd_addr       = idx_nx[AW-1:0];

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == NW'(MAX_BLOCKS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_nx;
            end
         end

         S_IDLE: begin
            // entry 0 is read ahead so a scan starts at once
            rd_addr = '0;
            if (accept) begin
               idx_in  = '0;
               pos_in  = '0;
               run_in  = '0;
               size_in = req_size_bytes;
               off_in  = req_address - heap_base_ff;
               if (req_operation == OP_FREE) begin
                  state_in = S_CHECK;
               end else if (req_size_bytes == '0 || n_used == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOMEM;
                  rsp_addr_in   = '0;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (rd_data[ENT_TAKEN]) begin
               run_in = '0;
            end else begin
               run_in       = new_run;
               start_in     = run_start;
               if (run_ff == '0) begin
                  start_pos_in = pos_ff;
               end
            end
            if (!rd_data[ENT_TAKEN] && CMPW'(new_run) >= CMPW'(size_ff)) begin
               idx_in   = run_start;
               end_in   = idx_ff;
               state_in = S_MARK;
            end else if (idx_nx == n_used) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOMEM;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_nx;
               pos_in = pos_ff + 32'(BLOCK_BYTES);
            end
         end

         S_MARK: begin
            wr_en              = 1'b1;
            wr_data[ENT_TAKEN] = 1'b1;
            wr_data[ENT_NEXT]  = (idx_ff != end_ff);
            if (idx_ff == end_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = heap_base_ff + start_pos_ff;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_nx;
            end
         end

         S_CHECK: begin
            rd_addr = blk[AW-1:0];
            if (blk >= 32'(n_used)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_RANGE;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in   = blk[NW-1:0];
               state_in = S_WALK;
            end
         end

         S_WALK: begin
            wr_en = 1'b1;
            if (!rd_data[ENT_NEXT] || idx_nx == n_used) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_nx;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe raised while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_operation == OP_FREE)) |=> busy)
      else $error("free item accepted without going busy");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_result_address == '0))
      else $error("failed item returned a nonzero address");

   a_mark_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (idx_ff <= end_ff))
      else $error("run marking passed the end of the run");

endmodule

`default_nettype wire

FILE: test/tb_block_table_heap_allocator_top.sv
// Testbench of the block table heap allocator: allocate and free items checked against a predictor.
`timescale 1ns / 1ps

module tb_block_table_heap_allocator_top;
   import bthalloc_pkg::*;

   localparam int unsigned BLOCK_BYTES   = 4096;
   localparam int unsigned MAX_BLOCKS    = 1024;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_CYCLES  = 2 * MAX_BLOCKS + 64;
   localparam int          RUN_LIMIT     = 6_000_000;

   typedef enum logic { SLOT_REQ, SLOT_CSR } slot_kind_e;

   typedef struct {
      slot_kind_e  kind;
      logic        op;
      logic [31:0] size;
      logic [31:0] addr;
      logic        idx;
      logic [31:0] data;
   } heap_slot_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] addr;
   } outcome_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_ALLOC;
   logic [31:0] req_size_bytes = '0;
   logic [31:0] req_address = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_result_address;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_HEAP_BASE;
   logic [31:0] csr_wdata = '0;

   // predictor state
   logic [1:0]      blk_tab [MAX_BLOCKS];
   logic [31:0]     cfg_base;
   logic [TB_W-1:0] cfg_blocks;

   heap_slot_t heap_ops_q[$];
   outcome_t   pending_outcomes[$];
   logic       item_ready = 1'b0;
   int         pending = 0;
   int         quiet = 0;
   int         items_taken = 0;
   int         bad_results = 0;
   int         cycles = 0;

   // generator view of the configuration
   logic [31:0] gen_base = '0;
   int unsigned gen_entries = MAX_BLOCKS;

   block_table_heap_allocator_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_size_bytes     (req_size_bytes),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic outcome_t heap_op_outcome(logic op, logic [31:0] size,
                                                logic [31:0] addr);
      outcome_t    r;
      logic [63:0] need;
      logic [31:0] offset;
      logic [1:0]  e;
      int unsigned n, i, first, run;
      bit          found;
      r.status = ST_OK;
      r.addr   = '0;
      n = (cfg_blocks > MAX_BLOCKS) ? MAX_BLOCKS : cfg_blocks;
      if (op == OP_ALLOC) begin
         need  = (64'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
         found = 1'b0;
         run   = 0;
         first = 0;
         if (need != 0 && need <= n) begin
            for (i = 0; i < n; i++) begin
               if (blk_tab[i][ENT_TAKEN]) begin
                  run = 0;
               end else begin
                  if (run == 0) first = i;
                  run++;
                  if (run == need) begin
                     found = 1'b1;
                     break;
                  end
               end
            end
         end
         if (!found) begin
            r.status = ST_NOMEM;
         end else begin
            for (i = first; i < first + need; i++) begin
               blk_tab[i] = 2'b00;
               blk_tab[i][ENT_TAKEN] = 1'b1;
               blk_tab[i][ENT_NEXT]  = (i + 1 < first + need);
            end
            r.addr = cfg_base + 32'(first * BLOCK_BYTES);
         end
      end else begin
         offset = addr - cfg_base;
         if (offset / BLOCK_BYTES >= n) begin
            r.status = ST_RANGE;
         end else begin
            for (i = offset / BLOCK_BYTES; i < n; i++) begin
               e = blk_tab[i];
               blk_tab[i] = 2'b00;
               if (!e[ENT_NEXT]) break;
            end
         end
      end
      return r;
   endfunction

   task automatic push_alloc(logic [31:0] size);
      heap_slot_t s;
      s = '{kind: SLOT_REQ, op: OP_ALLOC, size: size, addr: $urandom(), idx: 1'b0, data: '0};
      heap_ops_q.push_back(s);
   endtask

   task automatic push_free(logic [31:0] addr);
      heap_slot_t s;
      s = '{kind: SLOT_REQ, op: OP_FREE, size: $urandom(), addr: addr, idx: 1'b0, data: '0};
      heap_ops_q.push_back(s);
   endtask

   task automatic push_csr(logic idx, logic [31:0] data);
      heap_slot_t s;
      s = '{kind: SLOT_CSR, op: OP_ALLOC, size: '0, addr: '0, idx: idx, data: data};
      heap_ops_q.push_back(s);
      if (idx == CSR_HEAP_BASE) begin
         gen_base = data;
      end else begin
         gen_entries = data[TB_W-1:0];
         if (gen_entries > MAX_BLOCKS) gen_entries = MAX_BLOCKS;
      end
   endtask

   // mostly allocations and frees that land on the used table, some raw noise
   task automatic random_phase(int count);
      int unsigned span, k, blk, pick;
      logic [31:0] low;
      span = (gen_entries / 3 < 1) ? 1 : gen_entries / 3;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            k = $urandom_range(1, span);
            push_alloc((k - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
         end else if (pick < 88) begin
            blk = $urandom_range(0, (gen_entries < 1) ? 0 : gen_entries - 1);
            low = ($urandom_range(0, 2) == 0) ? $urandom_range(0, BLOCK_BYTES - 1) : 0;
            push_free(gen_base + blk * BLOCK_BYTES + low);
         end else if (pick < 94) begin
            push_alloc($urandom());
         end else begin
            push_free($urandom());
         end
      end
   endtask

   always @(posedge clock) begin : drive_heap_ops
      logic       took, loaded_n, we_n, idle_now;
      int         pend_n, quiet_n;
      heap_slot_t s;
      took = start && !busy;
      if (reset) begin
         start      <= 1'b0;
         csr_we     <= 1'b0;
         item_ready <= 1'b0;
         pending    <= 0;
         quiet      <= 0;
         cfg_base   = '0;
         cfg_blocks = TABLE_BLOCKS_RESET;
         for (int unsigned j = 0; j < MAX_BLOCKS; j++) blk_tab[j] = 2'b00;
      end else begin
         if (took) begin
            pending_outcomes.push_back(heap_op_outcome(req_operation, req_size_bytes,
                                                       req_address));
         end
         pend_n = pending + int'(took) - int'(rsp_valid);
         if (pend_n < 0) pend_n = 0;
         loaded_n = item_ready && !took;
         quiet_n  = (pend_n == 0 && !loaded_n) ? quiet + 1 : 0;
         we_n     = 1'b0;
         if (!loaded_n && heap_ops_q.size() != 0) begin
            s = heap_ops_q[0];
            if (s.kind == SLOT_REQ) begin
               heap_ops_q.pop_front();
               req_operation  <= s.op;
               req_size_bytes <= s.size;
               req_address    <= s.addr;
               loaded_n = 1'b1;
            end else if (quiet_n > SETTLE_CYCLES) begin
               // registers change only while the block is idle
               heap_ops_q.pop_front();
               csr_index <= s.idx;
               csr_wdata <= s.data;
               we_n = 1'b1;
               if (s.idx == CSR_HEAP_BASE) cfg_base = s.data;
               else cfg_blocks = s.data[TB_W-1:0];
               quiet_n = 0;
            end
         end
         idle_now = !(items_taken >= 250 && items_taken < 380) &&
                    ($urandom_range(0, 99) < 10);
         start      <= loaded_n && !idle_now;
         csr_we     <= we_n;
         item_ready <= loaded_n;
         pending    <= pend_n;
         quiet      <= quiet_n;
         if (took) items_taken <= items_taken + 1;
      end
   end

   always @(posedge clock) begin : check_results
      outcome_t want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            bad_results = bad_results + 1;
            if (bad_results <= 10)
               $display("unexpected item out: status %0d address %h", rsp_status,
                        rsp_result_address);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_result_address !== want.addr) begin
               bad_results = bad_results + 1;
               if (bad_results <= 10)
                  $display("mismatch: status exp %0d got %0d, address exp %h got %h",
                           want.status, rsp_status, want.addr, rsp_result_address);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] tmp, base;
      int unsigned blocks;
      // reset configuration: edges of size, chains, range and end of table
      push_alloc(32'd0);
      push_alloc(32'd1);
      push_alloc(32'd4096);
      push_alloc(32'd4097);
      push_alloc(32'hFFFF_FFFF);
      push_free(32'h0000_2123);
      push_free(32'h0000_2000);
      push_free(32'h0000_1000);
      push_free(32'hFFFF_FFFF);
      push_free(32'h0040_0000);
      push_alloc(1020 * BLOCK_BYTES);
      push_alloc(4 * BLOCK_BYTES);
      push_alloc(3 * BLOCK_BYTES);
      push_free(32'h0000_0000);
      push_free(32'h0000_1000);
      push_free(32'h003F_F000);
      // base near the top of the address space: result address wraps
      push_csr(CSR_HEAP_BASE, 32'hFFFF_E000);
      push_csr(CSR_TABLE_BLOCKS, 32'd4);
      push_alloc(3 * BLOCK_BYTES);
      push_alloc(32'd1);
      push_free(32'h0000_1000);
      push_free(32'hFFFF_D000);
      push_free(32'hFFFF_E000);
      push_alloc(4 * BLOCK_BYTES);
      // shrink the table under a live chain: walk stops at the last used entry
      push_csr(CSR_TABLE_BLOCKS, 32'd2);
      push_free(32'hFFFF_E000);
      push_csr(CSR_TABLE_BLOCKS, 32'd0);
      push_alloc(32'd1);
      push_free(32'hFFFF_E000);
      // oversized count with junk upper bits saturates to the table depth
      push_csr(CSR_TABLE_BLOCKS, 32'hFFFF_FFFF);
      push_csr(CSR_HEAP_BASE, 32'h0000_0000);
      push_alloc(32'd1);

      for (int ph = 0; ph < 14; ph++) begin
         tmp = $urandom();
         case ($urandom_range(0, 5))
            0:       base = 32'h0000_0000;
            1:       base = 32'hFFFF_F000;
            2:       base = tmp;
            default: base = tmp & 32'hFFFF_F000;
         endcase
         case ($urandom_range(0, 9))
            0:       blocks = 1;
            1:       blocks = 2;
            default: blocks = $urandom_range(3, 48);
         endcase
         push_csr(CSR_HEAP_BASE, base);
         push_csr(CSR_TABLE_BLOCKS, blocks);
         random_phase(40);
      end
      // a few items on the full table
      push_csr(CSR_HEAP_BASE, 32'hFFFF_FFFF);
      push_csr(CSR_TABLE_BLOCKS, MAX_BLOCKS);
      random_phase(12);

      while (reset) @(posedge clock);
      while (heap_ops_q.size() != 0 || item_ready || pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_results == 0 && pending_outcomes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : reset_seq
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

FILE: filelist.f
sv/bthalloc_pkg.sv
sv/bthalloc_ram.sv
sv/block_table_heap_allocator_top.sv
test/tb_block_table_heap_allocator_top.sv
